[rtl/core/sm4_pkg.sv]
// Shared types, constants and the SM4 round function for the cipher engine.
`timescale 1ns / 1ps

package sm4_pkg;

    localparam int NUM_ROUNDS = 32;
    localparam int KEY_IDX_W  = $clog2(NUM_ROUNDS);
    localparam int WORD_W     = 32;
    localparam int HALF_W     = 64;
    localparam int BLOCK_W    = 128;

    typedef enum logic [1:0] {
        OP_LOAD_KEY = 2'd0,
        OP_ENCRYPT  = 2'd1,
        OP_DECRYPT  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        CMD_KEY,
        CMD_ENC,
        CMD_DEC
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [KEY_IDX_W-1:0]   key_index;
        logic [WORD_W-1:0]      key_word;
        logic [BLOCK_W-1:0]     block;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic busy;
        logic last_round;
    } eng_status_t;

    localparam logic [7:0] SBOX [0:255] = '{
        8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
        8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
        8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
        8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
        8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
        8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
        8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
        8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
        8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
        8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
        8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
        8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
        8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
        8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
        8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
        8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
        8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
        8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
        8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
        8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
        8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
        8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
        8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
        8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
        8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
        8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
        8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
        8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
        8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
        8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
        8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
        8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
    };

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
        rotl = (x << n) | (x >> (WORD_W - n));
    endfunction

    // T transform: byte-wise S-box followed by the linear mix L
    function automatic logic [WORD_W-1:0] sm4_t(input logic [WORD_W-1:0] a);
        logic [WORD_W-1:0] b;
        b = {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
        sm4_t = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

endpackage

[rtl/core/sm4_block_cipher.sv]
// Top level of the SM4 block cipher engine.
`timescale 1ns / 1ps

// SM4 engine with a 32-entry round-key store. Opcode 0 writes one round key
// (no result), 1 encrypts and 2 decrypts a 128-bit block, opcode 3 is dropped.
// A block fetches the first key, then runs 32 rounds through a single shared
// round unit that reads one key per cycle from the key store; the last round
// waits until the previous result is taken. Commands pass through an input
// register and a QUEUE_DEPTH-entry queue, so new transactions are taken while
// the engine runs or a result waits. Keys used by a block must be loaded first.

module sm4_block_cipher
    import sm4_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_opcode,
    input  logic [KEY_IDX_W-1:0] s_key_index,
    input  logic [WORD_W-1:0]    s_key_word,
    input  logic [HALF_W-1:0]    s_block_high,
    input  logic [HALF_W-1:0]    s_block_low,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [HALF_W-1:0]    m_out_high,
    output logic [HALF_W-1:0]    m_out_low
);

    logic        push;
    cmd_t        push_cmd;
    logic        pop;
    cmd_t        head;
    q_status_t   q_stat;
    eng_status_t eng_stat;

    sm4_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_key_index  (s_key_index),
        .s_key_word   (s_key_word),
        .s_block_high (s_block_high),
        .s_block_low  (s_block_low),
        .q_stat       (q_stat),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    sm4_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    sm4_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .q_stat     (q_stat),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_high (m_out_high),
        .m_out_low  (m_out_low),
        .status     (eng_stat)
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty && !eng_stat.busy)
        else $error("engine pop while queue empty or busy");

    a_result_from_last_round: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(eng_stat.last_round))
        else $error("result raised without a finished last round");

endmodule

[rtl/core/sm4_front.sv]
// Input stage: accepts transactions, decodes the opcode and drops unused codes.
`timescale 1ns / 1ps

module sm4_front
    import sm4_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_opcode,
    input  logic [KEY_IDX_W-1:0] s_key_index,
    input  logic [WORD_W-1:0]    s_key_word,
    input  logic [HALF_W-1:0]    s_block_high,
    input  logic [HALF_W-1:0]    s_block_low,
    input  q_status_t            q_stat,
    output logic                 push,
    output cmd_t                 push_cmd
);

    logic      hold_valid_reg;
    logic      hold_valid_next;
    cmd_t      cmd_reg;
    logic      accept;
    logic      known;
    cmd_kind_t kind;

    always_comb begin
        known = 1'b1;
        kind  = CMD_KEY;
        case (opcode_t'(s_opcode))
            OP_LOAD_KEY: kind = CMD_KEY;
            OP_ENCRYPT:  kind = CMD_ENC;
            OP_DECRYPT:  kind = CMD_DEC;
            default:     known = 1'b0;
        endcase
    end

    assign push     = hold_valid_reg && !q_stat.full;
    assign s_ready  = !hold_valid_reg || push;
    assign accept   = s_valid && s_ready;
    assign push_cmd = cmd_reg;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (push) begin
            hold_valid_next = 1'b0;
        end
        if (accept && known) begin
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && known) begin
            cmd_reg <= '{kind: kind, key_index: s_key_index, key_word: s_key_word,
                         block: {s_block_high, s_block_low}};
        end
    end

endmodule

[rtl/core/sm4_cmd_queue.sv]
// Short command queue between the input stage and the round engine.
`timescale 1ns / 1ps

module sm4_cmd_queue
    import sm4_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      head,
    output q_status_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/core/sm4_engine.sv]
// Round engine: key store, one shared round unit and the result register.
`timescale 1ns / 1ps

module sm4_engine
    import sm4_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              head,
    input  q_status_t         q_stat,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [HALF_W-1:0] m_out_high,
    output logic [HALF_W-1:0] m_out_low,
    output eng_status_t       status
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [KEY_IDX_W-1:0] rnd_reg;
    logic [KEY_IDX_W-1:0] rnd_next;
    logic                 dec_reg;
    logic                 dec_next;
    logic [WORD_W-1:0]    w0_reg, w1_reg, w2_reg, w3_reg;
    logic [WORD_W-1:0]    w0_next, w1_next, w2_next, w3_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [HALF_W-1:0]    out_high_reg, out_high_next;
    logic [HALF_W-1:0]    out_low_reg, out_low_next;

    logic [WORD_W-1:0]    key_mem [NUM_ROUNDS];
    logic [WORD_W-1:0]    key_q_reg;

    logic                 out_free;
    logic                 start;
    logic                 key_wr;
    logic                 last;
    logic                 advance;
    logic                 rd_en;
    logic [KEY_IDX_W-1:0] rd_round;
    logic                 rd_dir;
    logic [KEY_IDX_W-1:0] rd_addr;
    logic [WORD_W-1:0]    new_word;

    assign out_free = !m_valid_reg || m_ready;
    assign pop      = (state_reg == ST_IDLE) && !q_stat.empty;
    assign start    = pop && (head.kind != CMD_KEY);
    assign key_wr   = pop && (head.kind == CMD_KEY);
    assign last     = (state_reg == ST_RUN) && (rnd_reg == KEY_IDX_W'(NUM_ROUNDS - 1));
    assign advance  = (state_reg == ST_RUN) && (!last || out_free);
    assign rd_en    = start || (advance && !last);
    assign rd_round = start ? '0 : rnd_reg + 1'b1;
    assign rd_dir   = start ? (head.kind == CMD_DEC) : dec_reg;
    assign rd_addr  = rd_dir ? KEY_IDX_W'(NUM_ROUNDS - 1) - rd_round : rd_round;

    assign new_word = w0_reg ^ sm4_t(w1_reg ^ w2_reg ^ w3_reg ^ key_q_reg);

    assign m_valid           = m_valid_reg;
    assign m_out_high        = out_high_reg;
    assign m_out_low         = out_low_reg;
    assign status.busy       = (state_reg == ST_RUN);
    assign status.last_round = last && advance;

    always_ff @(posedge aclk) begin
        if (key_wr) begin
            key_mem[head.key_index] <= head.key_word;
        end
        if (rd_en) begin
            key_q_reg <= key_mem[rd_addr];
        end
    end

    always_comb begin
        state_next    = state_reg;
        rnd_next      = rnd_reg;
        dec_next      = dec_reg;
        w0_next       = w0_reg;
        w1_next       = w1_reg;
        w2_next       = w2_reg;
        w3_next       = w3_reg;
        out_high_next = out_high_reg;
        out_low_next  = out_low_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_RUN;
                    rnd_next   = '0;
                    dec_next   = (head.kind == CMD_DEC);
                    {w0_next, w1_next, w2_next, w3_next} = head.block;
                end
            end
            ST_RUN: begin
                if (advance) begin
                    rnd_next = rnd_reg + 1'b1;
                    w0_next  = w1_reg;
                    w1_next  = w2_reg;
                    w2_next  = w3_reg;
                    w3_next  = new_word;
                    if (last) begin
                        state_next    = ST_IDLE;
                        out_high_next = {new_word, w3_reg};
                        out_low_next  = {w2_reg, w1_reg};
                        m_valid_next  = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        rnd_reg      <= rnd_next;
        dec_reg      <= dec_next;
        w0_reg       <= w0_next;
        w1_reg       <= w1_next;
        w2_reg       <= w2_next;
        w3_reg       <= w3_next;
        out_high_reg <= out_high_next;
        out_low_reg  <= out_low_next;
    end

endmodule

[test/sm4_block_cipher_tb.sv]
// Testbench for sm4_block_cipher: key loads and block transactions checked against a predictor.
`timescale 1ns / 1ps

package sm4_tb_pkg;
    import sm4_pkg::*;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
    } block_result_t;

    localparam logic [127:0] SUB_ROWS [16] = '{
        128'hd690e9fecce13db716b614c228fb2c05,
        128'h2b679a762abe04c3aa44132649860699,
        128'h9c4250f491ef987a33540b43edcfac62,
        128'he4b31ca9c908e89580df94fa758f3fa6,
        128'h4707a7fcf37317ba83593c19e6854fa8,
        128'h686b81b27164da8bf8eb0f4b70569d35,
        128'h1e240e5e6358d1a225227c3b01217887,
        128'hd40046579fd327524c3602e7a0c4c89e,
        128'heabf8ad240c738b5a3f7f2cef96115a1,
        128'he0ae5da49b341a55ad933230f58cb1e3,
        128'h1df6e22e8266ca60c02923ab0d534e6f,
        128'hd5db3745defd8e2f03ff6a726d6c5b51,
        128'h8d1baf92bbddbc7f11d95c411f105ad8,
        128'h0ac13188a5cd7bbd2d74d012b8e5b4b0,
        128'h8969974a0c96777e65b9f109c56ec684,
        128'h18f07dec3adc4d2079ee5f3ed7cb3948
    };

    class sm4_scoreboard;
        logic [31:0]   round_key [32];
        block_result_t expected_blocks [$];
        int            errors;

        function new();
            errors = 0;
            foreach (round_key[i]) round_key[i] = '0;
        endfunction

        function logic [7:0] sub_byte(logic [7:0] a);
            return SUB_ROWS[a[7:4]][8 * (15 - a[3:0]) +: 8];
        endfunction

        // byte substitution, then the linear mix with rotations 2, 10, 18, 24
        function logic [31:0] mix_word(logic [31:0] a);
            logic [31:0] b;
            b = {sub_byte(a[31:24]), sub_byte(a[23:16]), sub_byte(a[15:8]), sub_byte(a[7:0])};
            return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                     ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
        endfunction

        function block_result_t run_rounds(logic [63:0] hi, logic [63:0] lo, bit reverse);
            logic [31:0]   x [4];
            logic [31:0]   nx;
            logic [31:0]   k;
            block_result_t res;
            x[0] = hi[63:32];
            x[1] = hi[31:0];
            x[2] = lo[63:32];
            x[3] = lo[31:0];
            for (int r = 0; r < 32; r++) begin
                k = reverse ? round_key[31 - r] : round_key[r];
                nx = x[0] ^ mix_word(x[1] ^ x[2] ^ x[3] ^ k);
                x[0] = x[1];
                x[1] = x[2];
                x[2] = x[3];
                x[3] = nx;
            end
            res.out_high = {x[3], x[2]};
            res.out_low  = {x[1], x[0]};
            return res;
        endfunction

        function void note_input(logic [1:0] op, logic [4:0] idx, logic [31:0] key_word,
                                 logic [63:0] hi, logic [63:0] lo);
            case (op)
                OP_LOAD_KEY: round_key[idx] = key_word;
                OP_ENCRYPT:  expected_blocks.push_back(run_rounds(hi, lo, 1'b0));
                OP_DECRYPT:  expected_blocks.push_back(run_rounds(hi, lo, 1'b1));
                default: ;
            endcase
        endfunction

        function void check_result(logic [63:0] hi, logic [63:0] lo);
            block_result_t want;
            if (expected_blocks.size() == 0) begin
                $display("%0t: unexpected result expected none actual %h %h", $time, hi, lo);
                errors++;
                return;
            end
            want = expected_blocks.pop_front();
            if (hi !== want.out_high) begin
                $display("%0t: out_high expected %h actual %h", $time, want.out_high, hi);
                errors++;
            end
            if (lo !== want.out_low) begin
                $display("%0t: out_low expected %h actual %h", $time, want.out_low, lo);
                errors++;
            end
        endfunction
    endclass
endpackage

module sm4_block_cipher_tb;
    import sm4_pkg::*;
    import sm4_tb_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS    = 580;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int DRAIN_CYCLES    = 80;
    localparam int HOLD_OFF_CYCLES = 300;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode     = '0;
    logic [4:0]  s_key_index  = '0;
    logic [31:0] s_key_word   = '0;
    logic [63:0] s_block_high = '0;
    logic [63:0] s_block_low  = '0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [63:0] m_out_high;
    logic [63:0] m_out_low;

    int send_idle_pct    = 0;
    int recv_idle_pct    = 0;
    bit hold_off_request = 1'b0;
    int cycle_count      = 0;

    sm4_scoreboard blocks_sb = new();

    sm4_block_cipher i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_key_index  (s_key_index),
        .s_key_word   (s_key_word),
        .s_block_high (s_block_high),
        .s_block_low  (s_block_low),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_high   (m_out_high),
        .m_out_low    (m_out_low)
    );

    always #5 aclk = ~aclk;

    function automatic logic [63:0] rand_half();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [4:0] idx,
                             input logic [31:0] key_word, input logic [63:0] hi,
                             input logic [63:0] lo);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_key_index  <= idx;
        s_key_word   <= key_word;
        s_block_high <= hi;
        s_block_low  <= lo;
        do @(posedge aclk); while (!s_ready);
        blocks_sb.note_input(op, idx, key_word, hi, lo);
    endtask

    // decrypting the predicted ciphertext must give the plaintext back
    task automatic encrypt_round_trip(input logic [63:0] hi, input logic [63:0] lo);
        block_result_t ct;
        send_item(OP_ENCRYPT, 5'($urandom), $urandom, hi, lo);
        ct = blocks_sb.run_rounds(hi, lo, 1'b0);
        send_item(OP_DECRYPT, 5'($urandom), $urandom, ct.out_high, ct.out_low);
    endtask

    task automatic random_step(output int sent);
        int pick;
        pick = $urandom_range(0, 99);
        sent = 1;
        if (pick < 12) begin
            send_item(OP_LOAD_KEY, 5'($urandom), $urandom, rand_half(), rand_half());
        end else if (pick < 16) begin
            send_item(OP_UNUSED, 5'($urandom), $urandom, rand_half(), rand_half());
            sent = 0;
        end else if (pick < 30) begin
            encrypt_round_trip(rand_half(), rand_half());
            sent = 2;
        end else begin
            send_item($urandom_range(0, 1) ? OP_ENCRYPT : OP_DECRYPT, 5'($urandom), $urandom,
                      rand_half(), rand_half());
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) blocks_sb.check_result(m_out_high, m_out_low);
    end

    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int n;
        int sent;
        bit hold_off_sent;
        hold_off_sent = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 9;
        recv_idle_pct = 84;

        // fill every key slot before any block reads it
        for (int i = 0; i < 32; i++) begin
            send_item(OP_LOAD_KEY, 5'(i),
                      (i == 0) ? 32'h0 : (i == 31) ? 32'hffff_ffff : 32'($urandom),
                      i[0] ? '1 : '0, i[0] ? '0 : '1);
        end
        send_item(OP_ENCRYPT, '0, '0, '0, '0);
        send_item(OP_ENCRYPT, '1, '1, '1, '1);
        send_item(OP_DECRYPT, '0, '0, '0, '0);
        send_item(OP_DECRYPT, '1, '1, '1, '1);
        send_item(OP_UNUSED, '1, '1, '1, '1);
        send_item(OP_UNUSED, '0, '0, '0, '0);
        encrypt_round_trip({$urandom, $urandom}, {$urandom, $urandom});
        send_item(OP_LOAD_KEY, 5'd0, 32'hffff_ffff, '0, '0);
        send_item(OP_LOAD_KEY, 5'd31, 32'h0, '1, '1);
        send_item(OP_ENCRYPT, 5'($urandom), $urandom, {$urandom, $urandom}, '1);
        send_item(OP_DECRYPT, 5'($urandom), $urandom, '0, {$urandom, $urandom});

        n = 0;
        while (n < RANDOM_ITEMS) begin
            if (n >= 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                if (!hold_off_sent) begin
                    hold_off_request = 1'b1;
                    hold_off_sent = 1'b1;
                end
            end else if (n >= RANDOM_ITEMS / 3) begin
                send_idle_pct = 84;
                recv_idle_pct = 9;
            end
            random_step(sent);
            n += sent;
        end
        s_valid <= 1'b0;

        while (blocks_sb.expected_blocks.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (blocks_sb.errors == 0 && blocks_sb.expected_blocks.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
